[hdl/tbbs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbbs_pkg
// shared types and codes of the thread budget batch scheduler
// ----------------------------------------------------------------------------
package tbbs_pkg;

  localparam logic [2:0] ST_ACCEPTED   = 3'd0;
  localparam logic [2:0] ST_INVALID    = 3'd1;
  localparam logic [2:0] ST_FULL       = 3'd2;
  localparam logic [2:0] ST_EMPTY      = 3'd3;
  localparam logic [2:0] ST_DISPATCHED = 3'd4;

  localparam logic OP_ENQUEUE = 1'b0;
  localparam logic OP_ROUND   = 1'b1;

  localparam logic CFG_PROCESSORS = 1'b0;
  localparam logic CFG_BUDGET     = 1'b1;

  localparam logic [47:0] CPU_MAX = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic [15:0] id;
    logic [7:0]  threads;
    logic [15:0] quantum;
    logic [15:0] iters;
  } job_t;

  // controller to datapath
  typedef struct packed {
    logic load_in;     // capture input item
    logic enq_in;      // push captured job
    logic pop;         // read head into staging
    logic scan_eval;   // evaluate staged job
    logic round_init;  // start a round
    logic bat_rd;      // read batch entry
    logic emit_disp;   // build dispatch result
    logic emit_single; // build single result
    logic [2:0] status;
  } tbbs_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic op;
    logic in_ok;
    logic q_full;
    logic q_empty;
    logic scan_done;
    logic none_picked;
    logic bat_done;
  } tbbs_sts_t;

endpackage

[hdl/tbbs_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbbs_datapath
// job queue memory, batch store, budget tracking and result register
// ----------------------------------------------------------------------------
module tbbs_datapath #(
  parameter int QUEUE_DEPTH = 64,
  parameter int MAX_SLOTS   = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic                cfg_index,
  input  logic [7:0]          cfg_wr_data,
  input  logic [56:0]         in_tdata,
  input  tbbs_pkg::tbbs_cmd_t cmd,
  output tbbs_pkg::tbbs_sts_t sts,
  output logic [127:0]        res_data,
  output logic                res_last
);

  localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int PW = $clog2(MAX_SLOTS + 1);

  tbbs_pkg::job_t job_mem [QUEUE_DEPTH];
  tbbs_pkg::job_t bat_mem [MAX_SLOTS];

  logic [4:0]  proc_r;
  logic [7:0]  budget_r;
  logic        op_r;
  tbbs_pkg::job_t in_job_r, stage_r, bat_q_r;
  logic [QW-1:0] head_r, tail_r;
  logic [CW-1:0] count_r, pending_r;
  logic [PW-1:0] picked_r, bidx_r;
  logic [7:0]  avail_r;
  logic [47:0] cpu_r;
  logic [127:0] res_r;
  logic        res_last_r;

  logic [PW-1:0] cap;
  logic          push, take;
  tbbs_pkg::job_t push_job, dec_job;
  logic [48:0]   cpu_sum;
  logic [47:0]   cpu_new;

  assign cap = ({{(PW > 5 ? PW - 5 : 0){1'b0}}, proc_r} > PW'(MAX_SLOTS)) ?
               PW'(MAX_SLOTS) : PW'(proc_r);
  assign take = cmd.scan_eval && (picked_r < cap) && (stage_r.threads <= avail_r);

  always_comb begin
    dec_job = bat_q_r;
    dec_job.iters = bat_q_r.iters - 16'd1;
  end

  assign push = cmd.enq_in || (cmd.scan_eval && !take) ||
                (cmd.emit_disp && dec_job.iters != 16'd0);
  assign push_job = cmd.enq_in ? in_job_r : (cmd.scan_eval ? stage_r : dec_job);

  assign cpu_sum = {1'b0, cpu_r} + {33'd0, bat_q_r.quantum};
  assign cpu_new = cpu_sum[48] ? tbbs_pkg::CPU_MAX : cpu_sum[47:0];

  assign sts.op          = op_r;
  assign sts.in_ok       = (in_job_r.id != 16'd0) && (in_job_r.threads != 8'd0) &&
                           (in_job_r.quantum != 16'd0) && (in_job_r.iters != 16'd0) &&
                           (in_job_r.threads <= budget_r);
  assign sts.q_full      = (count_r == CW'(QUEUE_DEPTH));
  assign sts.q_empty     = (count_r == '0);
  assign sts.scan_done   = (pending_r == '0);
  assign sts.none_picked = (picked_r == '0);
  assign sts.bat_done    = (bidx_r == picked_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      proc_r   <= 5'd1;
      budget_r <= 8'd1;
      head_r   <= '0;
      tail_r   <= '0;
      count_r  <= '0;
      cpu_r    <= '0;
    end else begin
      if (cfg_wr_en && cfg_index == tbbs_pkg::CFG_PROCESSORS) proc_r <= cfg_wr_data[4:0];
      if (cfg_wr_en && cfg_index == tbbs_pkg::CFG_BUDGET) budget_r <= cfg_wr_data;
      if (push) tail_r <= (tail_r == QW'(QUEUE_DEPTH - 1)) ? '0 : tail_r + 1'b1;
      if (cmd.pop) head_r <= (head_r == QW'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
      count_r <= count_r + CW'(push) - CW'(cmd.pop);
      if (cmd.emit_disp) cpu_r <= cpu_new;
    end
  end

  // queue and batch memories with registered reads
  always_ff @(posedge clk) begin
    if (push) job_mem[tail_r] <= push_job;
    if (cmd.pop) stage_r <= job_mem[head_r];
    if (take) bat_mem[picked_r[SW-1:0]] <= stage_r;
    if (cmd.bat_rd) bat_q_r <= bat_mem[bidx_r[SW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r     <= in_tdata[0];
      in_job_r <= '{id: in_tdata[16:1], threads: in_tdata[24:17],
                    quantum: in_tdata[40:25], iters: in_tdata[56:41]};
    end
    if (cmd.round_init) begin
      pending_r <= count_r;
      picked_r  <= '0;
      avail_r   <= budget_r;
      bidx_r    <= '0;
    end
    if (cmd.pop) pending_r <= pending_r - 1'b1;
    if (take) begin
      picked_r <= picked_r + 1'b1;
      avail_r  <= avail_r - stage_r.threads;
    end
    if (cmd.bat_rd) bidx_r <= bidx_r + 1'b1;
    if (cmd.emit_single) begin
      res_r      <= {7'd0, 1'b1, cpu_r, 8'd0, 1'b0, 16'd0, 16'd0, 8'd0, 16'd0, 4'd0,
                     cmd.status};
      res_last_r <= 1'b1;
    end
    if (cmd.emit_disp) begin
      res_r      <= {7'd0, sts.bat_done, cpu_new, budget_r - avail_r,
                     dec_job.iters == 16'd0, dec_job.iters, bat_q_r.quantum,
                     bat_q_r.threads, bat_q_r.id, 4'(bidx_r - 1'b1),
                     tbbs_pkg::ST_DISPATCHED};
      res_last_r <= sts.bat_done;
    end
  end

  assign res_data = res_r;
  assign res_last = res_last_r;

endmodule

[hdl/tbbs_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbbs_ctrl
// sequencer for enqueue, round scan and batch emit
// ----------------------------------------------------------------------------
module tbbs_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  input  tbbs_pkg::tbbs_sts_t sts,
  output tbbs_pkg::tbbs_cmd_t cmd
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_DEC   = 8'b0000_0010,
    S_POP   = 8'b0000_0100,
    S_EVAL  = 8'b0000_1000,
    S_BRD   = 8'b0001_0000,
    S_EMIT  = 8'b0010_0000,
    S_OUT   = 8'b0100_0000,
    S_WAIT  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   more_r, more_nxt;

  assign in_tready  = (state_r == S_IDLE) && !out_valid_r;
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    more_nxt      = more_r;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        cmd.load_in = in_tvalid && in_tready;
        if (in_tvalid && in_tready) state_nxt = S_DEC;
      end
      S_DEC: begin
        cmd.emit_single = 1'b1;
        if (sts.op == tbbs_pkg::OP_ENQUEUE) begin
          if (!sts.in_ok) cmd.status = tbbs_pkg::ST_INVALID;
          else if (sts.q_full) cmd.status = tbbs_pkg::ST_FULL;
          else begin
            cmd.status = tbbs_pkg::ST_ACCEPTED;
            cmd.enq_in = 1'b1;
          end
          state_nxt = S_OUT;
        end else if (sts.q_empty) begin
          cmd.status = tbbs_pkg::ST_EMPTY;
          state_nxt  = S_OUT;
        end else begin
          cmd.emit_single = 1'b0;
          cmd.round_init  = 1'b1;
          state_nxt       = S_POP;
        end
      end
      S_POP: begin
        if (sts.scan_done) begin
          if (sts.none_picked) begin
            cmd.emit_single = 1'b1;
            cmd.status      = tbbs_pkg::ST_INVALID;
            state_nxt       = S_OUT;
          end else state_nxt = S_BRD;
        end else begin
          cmd.pop   = 1'b1;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.scan_eval = 1'b1;
        state_nxt     = S_POP;
      end
      S_BRD: begin
        cmd.bat_rd = 1'b1;
        state_nxt  = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit_disp = 1'b1;
        more_nxt      = !sts.bat_done;
        out_valid_nxt = 1'b1;
        state_nxt     = S_WAIT;
      end
      S_OUT: begin
        out_valid_nxt = 1'b1;
        more_nxt      = 1'b0;
        state_nxt     = S_WAIT;
      end
      S_WAIT: begin
        if (!out_valid_r || out_tready) state_nxt = more_r ? S_BRD : S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      more_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      more_r      <= more_nxt;
    end
  end

endmodule

[hdl/thread_budget_batch_scheduler.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thread_budget_batch_scheduler
// fifo job queue with first-fit round scheduling under a thread budget
// ----------------------------------------------------------------------------
//  channel | direction | contents
//  in_     | slave     | tdata: operation, job_id, job_threads, job_quantum, job_iterations
//  out_    | master    | tdata: status .. cpu_time, tlast: last
//  cfg_    | write     | 0 processors, 1 thread_budget
//
// enqueue: each item is answered before the next is taken. round: the queued
// jobs are popped and evaluated one by one, then each picked job is read back and emitted.
// reset is synchronous; the memories need no clearing.
// a stalled output holds the sequencer until the transfer completes.
module thread_budget_batch_scheduler #(
  parameter int QUEUE_DEPTH = 64,
  parameter int MAX_SLOTS   = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_wr_en,
  input  logic         cfg_index,
  input  logic [7:0]   cfg_wr_data,
  input  logic         in_tvalid,
  output logic         in_tready,
  // operation, job_id, job_threads, job_quantum, job_iterations, pad
  input  logic [63:0]  in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // status, slot, out_job_id, out_threads, out_quantum, remaining, finished,
  // threads_used, cpu_time
  output logic [119:0] out_tdata,
  output logic         out_tlast
);

  tbbs_pkg::tbbs_cmd_t cmd;
  tbbs_pkg::tbbs_sts_t sts;
  logic [127:0]        res_data;

  tbbs_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready, .sts, .cmd
  );

  tbbs_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH), .MAX_SLOTS(MAX_SLOTS)) u_dp (
    .clk, .rst_n, .cfg_wr_en, .cfg_index, .cfg_wr_data,
    .in_tdata(in_tdata[56:0]), .cmd, .sts, .res_data, .res_last(out_tlast)
  );

  assign out_tdata = res_data[119:0];

endmodule

[hdl/tbbs_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbbs_checker
// port level checks of the scheduler
// ----------------------------------------------------------------------------
module tbbs_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [119:0] out_tdata,
  input logic         out_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output changed under stall");

  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input taken while result pending");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2:0] != tbbs_pkg::ST_DISPATCHED |-> out_tlast)
    else $error("single result without last");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[2:0] <= tbbs_pkg::ST_DISPATCHED)
    else $error("bad status code");

endmodule

bind thread_budget_batch_scheduler tbbs_checker u_chk (
  .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready, .out_tdata, .out_tlast
);

[tb/tb_thread_budget_batch_scheduler.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_thread_budget_batch_scheduler
// self-checking bench for the thread budget batch scheduler: directed and
// random job streams under several slot and budget settings, each result
// checked field by field against a cycle-free scheduling model
// ----------------------------------------------------------------------------
module tb_thread_budget_batch_scheduler;

  localparam int QDEPTH    = 64;
  localparam int SLOTS     = 16;
  localparam int MAX_CYCLE = 2000000;

  typedef struct packed {
    logic [6:0]  pad;
    logic [15:0] iters;
    logic [15:0] quantum;
    logic [7:0]  threads;
    logic [15:0] id;
    logic        op;
  } item_t;

  typedef struct packed {
    logic [47:0] cpu_time;
    logic [7:0]  threads_used;
    logic        finished;
    logic [15:0] remaining;
    logic [15:0] quantum;
    logic [7:0]  threads;
    logic [15:0] id;
    logic [3:0]  slot;
    logic [2:0]  status;
  } result_t;

  typedef struct packed {
    result_t r;
    logic    last;
  } sched_exp_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_wr_en = 1'b0;
  logic         cfg_index = 1'b0;
  logic [7:0]   cfg_wr_data = 8'd0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [63:0]  in_tdata = 64'd0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [119:0] out_tdata;
  logic         out_tlast;

  // scheduling model state
  tbbs_pkg::job_t model_jobs[$];
  logic [47:0]    model_cpu;
  logic [4:0]     model_procs;
  logic [7:0]     model_budget;

  item_t      pending_items[$];
  sched_exp_t expected_results[$];
  int         errors = 0;
  int         cycles = 0;
  bit         calm = 1'b0;
  bit         in_sent = 1'b0;
  int         in_gap = 0;
  int         out_gap = 0;

  thread_budget_batch_scheduler u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast)
  );

  always #5 clk = ~clk;

  function automatic sched_exp_t single_result(logic [2:0] st);
    sched_exp_t e;
    e = '0;
    e.r.status = st;
    e.r.cpu_time = model_cpu;
    e.last = 1'b1;
    return e;
  endfunction

  task automatic schedule_item(item_t it);
    tbbs_pkg::job_t j;
    tbbs_pkg::job_t batch[$];
    int          cap;
    int          avail;
    int          cnt;
    sched_exp_t  e;
    logic [48:0] sum;
    if (it.op == tbbs_pkg::OP_ENQUEUE) begin
      j.id = it.id; j.threads = it.threads; j.quantum = it.quantum; j.iters = it.iters;
      if (j.id == 0 || j.threads == 0 || j.quantum == 0 || j.iters == 0 ||
          j.threads > model_budget) begin
        expected_results.push_back(single_result(tbbs_pkg::ST_INVALID));
      end else if (model_jobs.size() >= QDEPTH) begin
        expected_results.push_back(single_result(tbbs_pkg::ST_FULL));
      end else begin
        model_jobs.push_back(j);
        expected_results.push_back(single_result(tbbs_pkg::ST_ACCEPTED));
      end
      return;
    end
    if (model_jobs.size() == 0) begin
      expected_results.push_back(single_result(tbbs_pkg::ST_EMPTY));
      return;
    end
    cap = (model_procs > SLOTS) ? SLOTS : model_procs;
    avail = model_budget;
    cnt = model_jobs.size();
    for (int i = 0; i < cnt; i++) begin
      j = model_jobs.pop_front();
      if (batch.size() < cap && j.threads <= avail) begin
        batch.push_back(j);
        avail -= j.threads;
      end else begin
        model_jobs.push_back(j);
      end
    end
    if (batch.size() == 0) begin
      expected_results.push_back(single_result(tbbs_pkg::ST_INVALID));
      return;
    end
    foreach (batch[i]) begin
      sum = model_cpu + batch[i].quantum;
      model_cpu = sum[48] ? tbbs_pkg::CPU_MAX : sum[47:0];
      batch[i].iters = batch[i].iters - 16'd1;
      if (batch[i].iters != 0) model_jobs.push_back(batch[i]);
      e = '0;
      e.r.status = tbbs_pkg::ST_DISPATCHED;
      e.r.slot = i[3:0];
      e.r.id = batch[i].id;
      e.r.threads = batch[i].threads;
      e.r.quantum = batch[i].quantum;
      e.r.remaining = batch[i].iters;
      e.r.finished = (batch[i].iters == 0);
      e.r.threads_used = model_budget - avail[7:0];
      e.r.cpu_time = model_cpu;
      e.last = (i == batch.size() - 1);
      expected_results.push_back(e);
    end
  endtask

  task automatic check_field(string name, logic [47:0] exp_v, logic [47:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      if (errors <= 10)
        $display("%0t %s: expected %0h, got %0h", $realtime, name, exp_v, act_v);
    end
  endtask

  // input driver and output ready stalls
  always @(negedge clk) begin
    if (!in_tvalid || in_sent) begin
      in_sent = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        in_tvalid <= 1'b1;
        in_tdata <= pending_items.pop_front();
        if (!calm && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 12);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
    if (out_gap > 0) begin
      out_gap--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if (!calm && $urandom_range(0, 6) == 0) out_gap = $urandom_range(1, 12);
    end
  end

  // acceptance, prediction and result monitor
  always @(posedge clk) begin
    result_t    act;
    sched_exp_t e;
    cycles++;
    if (cycles > MAX_CYCLE) begin
      $display("thread_budget_batch_scheduler: mismatch");
      $finish;
    end else begin
      if (rst_n && in_tvalid && in_tready) begin
        schedule_item(item_t'(in_tdata));
        in_sent = 1'b1;
      end
      if (rst_n && out_tvalid && out_tready) begin
        act = result_t'(out_tdata);
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= 10) $display("%0t unexpected result %h", $realtime, out_tdata);
        end else begin
          e = expected_results.pop_front();
          check_field("status", e.r.status, act.status);
          check_field("slot", e.r.slot, act.slot);
          check_field("job_id", e.r.id, act.id);
          check_field("threads", e.r.threads, act.threads);
          check_field("quantum", e.r.quantum, act.quantum);
          check_field("remaining", e.r.remaining, act.remaining);
          check_field("finished", e.r.finished, act.finished);
          check_field("threads_used", e.r.threads_used, act.threads_used);
          check_field("cpu_time", e.r.cpu_time, act.cpu_time);
          check_field("last", e.last, out_tlast);
        end
      end
    end
  end

  function automatic item_t make_job(logic [15:0] id, logic [7:0] thr,
                                     logic [15:0] q, logic [15:0] it);
    item_t x;
    x = '0;
    x.op = tbbs_pkg::OP_ENQUEUE; x.id = id; x.threads = thr; x.quantum = q; x.iters = it;
    return x;
  endfunction

  function automatic item_t make_round();
    item_t x;
    x = '0;
    x.op = tbbs_pkg::OP_ROUND;
    // junk in the unused fields of a round
    x.id = 16'($urandom); x.threads = 8'($urandom);
    x.quantum = 16'($urandom); x.iters = 16'($urandom);
    return x;
  endfunction

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_items.size() > 0 || in_tvalid || expected_results.size() > 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [7:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wr_data <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == tbbs_pkg::CFG_PROCESSORS) model_procs = val[4:0];
    else model_budget = val;
  endtask

  task automatic random_job(int b);
    int k;
    logic [7:0] thr;
    k = $urandom_range(0, 9);
    thr = (b == 0) ? 8'd1 : 8'($urandom_range(1, b));
    if (k == 0)
      pending_items.push_back(make_job(16'($urandom), 8'($urandom), 16'($urandom),
                                       16'($urandom)));
    else if (k == 1)
      pending_items.push_back(make_job(16'($urandom), thr, 16'($urandom),
                                       16'($urandom_range(1, 40))));
    else
      pending_items.push_back(make_job(16'($urandom_range(1, 65535)), thr,
                                       16'($urandom_range(1, 65535)),
                                       16'($urandom_range(1, 3))));
  endtask

  initial begin
    int p;
    int b;
    model_cpu = '0;
    model_procs = 5'd1;
    model_budget = 8'd1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: reset settings, malformed jobs, extremes
    pending_items.push_back(make_round());
    pending_items.push_back(make_job(16'd0, 8'd1, 16'd5, 16'd1));
    pending_items.push_back(make_job(16'd7, 8'd0, 16'd5, 16'd1));
    pending_items.push_back(make_job(16'd7, 8'd1, 16'd0, 16'd1));
    pending_items.push_back(make_job(16'd7, 8'd1, 16'd5, 16'd0));
    pending_items.push_back(make_job(16'd7, 8'd2, 16'd5, 16'd1));
    pending_items.push_back(make_job(16'hFFFF, 8'd1, 16'hFFFF, 16'd1));
    pending_items.push_back(make_job(16'h0001, 8'd1, 16'h0001, 16'd2));
    pending_items.push_back(make_round());
    pending_items.push_back(make_round());
    pending_items.push_back(make_round());
    wait_idle();

    write_reg(tbbs_pkg::CFG_PROCESSORS, 8'd16);
    write_reg(tbbs_pkg::CFG_BUDGET, 8'd255);
    pending_items.push_back(make_job(16'hAAAA, 8'd255, 16'h5555, 16'hFFFF));
    pending_items.push_back(make_job(16'h5555, 8'hAA, 16'hAAAA, 16'd1));
    pending_items.push_back(make_job(16'h1234, 8'h55, 16'h00FF, 16'd2));
    pending_items.push_back(make_job(16'h4321, 8'd200, 16'd9, 16'd1));
    pending_items.push_back(make_round());
    pending_items.push_back(make_round());
    wait_idle();

    // nothing runnable: budget lowered under every waiting job
    write_reg(tbbs_pkg::CFG_BUDGET, 8'd10);
    pending_items.push_back(make_round());
    wait_idle();
    // and no slots at all
    write_reg(tbbs_pkg::CFG_PROCESSORS, 8'd0);
    write_reg(tbbs_pkg::CFG_BUDGET, 8'd255);
    pending_items.push_back(make_round());
    wait_idle();
    // slot count above the limit, then drain the wide job
    write_reg(tbbs_pkg::CFG_PROCESSORS, 8'd31);
    pending_items.push_back(make_round());
    wait_idle();

    // fill the queue to overflow
    write_reg(tbbs_pkg::CFG_PROCESSORS, 8'd16);
    for (int i = 0; i < QDEPTH + 2; i++)
      pending_items.push_back(make_job(16'($urandom_range(1, 65535)),
                                       8'($urandom_range(1, 4)),
                                       16'($urandom_range(1, 65535)), 16'd1));
    pending_items.push_back(make_round());
    wait_idle();
    // drain
    for (int i = 0; i < 6; i++) pending_items.push_back(make_round());
    wait_idle();

    // random phases
    for (int ph = 0; ph < 7; ph++) begin
      if (ph == 5) calm = 1'b1;
      case (ph)
        0: begin p = 1; b = 255; end
        1: begin p = 16; b = 1; end
        default: begin
          p = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 16);
          b = $urandom_range(1, 255);
        end
      endcase
      write_reg(tbbs_pkg::CFG_PROCESSORS, p[7:0]);
      write_reg(tbbs_pkg::CFG_BUDGET, b[7:0]);
      for (int n = 0; n < 22; n++) begin
        if ($urandom_range(0, 9) < 7) random_job(b);
        else pending_items.push_back(make_round());
      end
      wait_idle();
    end

    repeat (200) @(posedge clk);
    if (errors == 0)
      $display("thread_budget_batch_scheduler: match");
    else
      $display("thread_budget_batch_scheduler: mismatch");
    $finish;
  end

endmodule
